@@ src/zrot_pkg.sv @@
// Shared types, constants and the arctangent table for the z-axis point rotator.
`timescale 1ns / 1ps
`default_nettype none

package zrot_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int GUARD_BITS = 8;
  localparam int WORK_W = COORD_W + GUARD_BITS + 2;
  localparam int RES_W = 34;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES = 32;

  // Reciprocal of the CORDIC gain, unsigned fraction over 2^32.
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Z = 2'd2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81,
    32'd41, 32'd20, 32'd10, 32'd5,
    32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] turn_angle;
    logic               final_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
    logic                      final_point;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/zrot_prescale.sv @@
// Quadrant fold of the angle and gain compensation of the start point, two register stages.
`timescale 1ns / 1ps
`default_nettype none

module zrot_prescale (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [zrot_pkg::ANGLE_W-1:0]        angle,
  input  wire logic                                final_in,
  input  wire logic signed [zrot_pkg::COORD_W-1:0] start_x,
  input  wire logic signed [zrot_pkg::COORD_W-1:0] start_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [zrot_pkg::WORK_W-1:0]       x_out,
  output logic signed [zrot_pkg::WORK_W-1:0]       y_out,
  output logic signed [zrot_pkg::RES_W-1:0]        r_out,
  output logic                                     final_out
);
  import zrot_pkg::*;

  localparam int PROD_W = 64;
  localparam int DROP = 32 - GUARD_BITS;
  localparam int MAG_W = PROD_W - DROP;
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (DROP - 1);

  logic [31:0] turn;
  logic [31:0] folded;
  logic        flip;
  logic [31:0] mag_x;
  logic [31:0] mag_y;

  logic                     vld_a;
  logic                     rdy_a;
  logic [PROD_W-1:0]        prod_x;
  logic [PROD_W-1:0]        prod_y;
  logic                     neg_x;
  logic                     neg_y;
  logic signed [RES_W-1:0]  res_a;
  logic                     final_a;

  logic                     rdy_b;
  logic [PROD_W-1:0]        rnd_x;
  logic [PROD_W-1:0]        rnd_y;
  logic [WORK_W-1:0]        ext_x;
  logic [WORK_W-1:0]        ext_y;

  assign turn   = {angle, {(32 - ANGLE_W){1'b0}}};
  assign flip   = turn[31] ^ turn[30];
  assign folded = {turn[31] ^ flip, turn[30:0]};
  assign mag_x  = start_x[COORD_W-1] ? 32'(-start_x) : 32'(start_x);
  assign mag_y  = start_y[COORD_W-1] ? 32'(-start_y) : 32'(start_y);

  assign rdy_b    = ~out_valid | out_ready;
  assign rdy_a    = ~vld_a | rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (rdy_a) begin
      vld_a <= in_valid;
    end
    if (rdy_a) begin
      prod_x  <= {32'b0, mag_x} * {32'b0, INV_GAIN};
      prod_y  <= {32'b0, mag_y} * {32'b0, INV_GAIN};
      neg_x   <= start_x[COORD_W-1] ^ flip;
      neg_y   <= start_y[COORD_W-1] ^ flip;
      res_a   <= {{(RES_W - 32){folded[31]}}, folded};
      final_a <= final_in;
    end
  end

  assign rnd_x = prod_x + ROUND;
  assign rnd_y = prod_y + ROUND;
  assign ext_x = {{(WORK_W - MAG_W){1'b0}}, rnd_x[PROD_W-1:DROP]};
  assign ext_y = {{(WORK_W - MAG_W){1'b0}}, rnd_y[PROD_W-1:DROP]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_b) begin
      out_valid <= vld_a;
    end
    if (rdy_b) begin
      x_out     <= neg_x ? -$signed(ext_x) : $signed(ext_x);
      y_out     <= neg_y ? -$signed(ext_y) : $signed(ext_y);
      r_out     <= res_a;
      final_out <= final_a;
    end
  end

endmodule

`default_nettype wire

@@ src/zrot_cordic_stage.sv @@
// One registered CORDIC micro-rotation stage.
`timescale 1ns / 1ps
`default_nettype none

module zrot_cordic_stage #(
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN_STEP = 32'd0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [zrot_pkg::WORK_W-1:0] x_in,
  input  wire logic signed [zrot_pkg::WORK_W-1:0] y_in,
  input  wire logic signed [zrot_pkg::RES_W-1:0]  r_in,
  input  wire logic                               final_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [zrot_pkg::WORK_W-1:0]      x_out,
  output logic signed [zrot_pkg::WORK_W-1:0]      y_out,
  output logic signed [zrot_pkg::RES_W-1:0]       r_out,
  output logic                                    final_out
);
  import zrot_pkg::*;

  logic signed [WORK_W-1:0] dx;
  logic signed [WORK_W-1:0] dy;
  logic signed [RES_W-1:0]  step;

  assign dx       = y_in >>> SHIFT;
  assign dy       = x_in >>> SHIFT;
  assign step     = $signed({{(RES_W - 32){1'b0}}, ATAN_STEP});
  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      if (!r_in[RES_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        r_out <= r_in - step;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        r_out <= r_in + step;
      end
      final_out <= final_in;
    end
  end

endmodule

`default_nettype wire

@@ src/zrot_finish.sv @@
// Guard-bit rounding, saturation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module zrot_finish (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [zrot_pkg::WORK_W-1:0]  x_in,
  input  wire logic signed [zrot_pkg::WORK_W-1:0]  y_in,
  input  wire logic signed [zrot_pkg::COORD_W-1:0] z_in,
  input  wire logic                                final_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output zrot_pkg::out_item_t                      out_data
);
  import zrot_pkg::*;

  localparam int SH_W = WORK_W - GUARD_BITS;
  localparam logic signed [WORK_W-1:0] HALF = WORK_W'(1) << (GUARD_BITS - 1);

  function automatic logic [COORD_W-1:0] saturate(input logic [SH_W-1:0] v);
    logic [SH_W-COORD_W:0] top;
    begin
      top = v[SH_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
        saturate = v[COORD_W-1:0];
      end else if (v[SH_W-1]) begin
        saturate = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
        saturate = {1'b0, {(COORD_W - 1){1'b1}}};
      end
    end
  endfunction

  logic signed [WORK_W-1:0] rx;
  logic signed [WORK_W-1:0] ry;

  assign rx       = x_in + HALF;
  assign ry       = y_in + HALF;
  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data.rot_x       <= $signed(saturate(rx[WORK_W-1:GUARD_BITS]));
      out_data.rot_y       <= $signed(saturate(ry[WORK_W-1:GUARD_BITS]));
      out_data.rot_z       <= z_in;
      out_data.final_point <= final_in;
    end
  end

endmodule

`default_nettype wire

@@ src/z_axis_point_rotator.sv @@
// Top level of the z-axis point rotator: configuration registers and the CORDIC pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Rotates the configured point (start_x, start_y, start_z) about the z axis by each incoming
// binary angle and returns the rotated x and y, saturated to Q15.16, with z and the last-of-run
// flag passed along. The pipeline takes one transaction per clock cycle unless the output
// stalls. An accepted angle passes the two registers of the quadrant fold and gain multiply,
// one register per micro-rotation stage and one for rounding and saturation. Every
// stage holds its own valid bit, so bubbles close up while the output waits. The start point
// registers are written through the cfg port and must only change while no transaction is in
// flight.
module z_axis_point_rotator #(
  parameter int CORDIC_STAGES = zrot_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [zrot_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [zrot_pkg::COORD_W-1:0]          cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire zrot_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output zrot_pkg::out_item_t                        out_data
);
  import zrot_pkg::*;

  localparam int N = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;

  logic                     cv   [0:N];
  logic                     cr   [0:N];
  logic signed [WORK_W-1:0] cx   [0:N];
  logic signed [WORK_W-1:0] cy   [0:N];
  logic signed [RES_W-1:0]  cres [0:N];
  logic                     cfin [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      start_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_X: start_x <= $signed(cfg_wdata);
        REG_START_Y: start_y <= $signed(cfg_wdata);
        REG_START_Z: start_z <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  zrot_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .angle     (in_data.turn_angle),
    .final_in  (in_data.final_angle),
    .start_x   (start_x),
    .start_y   (start_y),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .x_out     (cx[0]),
    .y_out     (cy[0]),
    .r_out     (cres[0]),
    .final_out (cfin[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_stage
    zrot_cordic_stage #(
      .SHIFT     (k),
      .ATAN_STEP (ATAN_TURNS[k])
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .x_in      (cx[k]),
      .y_in      (cy[k]),
      .r_in      (cres[k]),
      .final_in  (cfin[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .x_out     (cx[k+1]),
      .y_out     (cy[k+1]),
      .r_out     (cres[k+1]),
      .final_out (cfin[k+1])
    );
  end

  zrot_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[N]),
    .in_ready  (cr[N]),
    .x_in      (cx[N]),
    .y_in      (cy[N]),
    .z_in      (start_z),
    .final_in  (cfin[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // When the consumer takes results, every stage can advance, so the input must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("ready chain broken");

  // A new result only appears when the last rotation stage held a transaction.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cv[N]))
    else $error("result without a transaction in the last stage");
`endif

endmodule

`default_nettype wire

@@ sim/z_axis_point_rotator_test.sv @@
// Self-checking testbench that rotates configured points by swept and random angles and checks every result.
`timescale 1ns / 1ps

module z_axis_point_rotator_test;
  import zrot_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int GUARD = 8;
  localparam int PHASES = 10;
  localparam int PHASE_ANGLES = 133;
  localparam logic [63:0] INV_GAIN_Q32 = 64'h9B74EDA8;
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam longint ATAN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  localparam logic [ANGLE_W-1:0] SWEEP [14] = '{
    16'h0000, 16'h0001, 16'h2000, 16'h3FFF, 16'h4000, 16'h4001, 16'h6000,
    16'h7FFF, 16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hE000, 16'hFFFF
  };

  localparam logic [ANGLE_W-1:0] DIAGONALS [5] = '{
    16'h0000, 16'h2000, 16'h6000, 16'hA000, 16'hE000
  };

  class rotation_checker;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    out_item_t pending_points[$];
    int mismatches;

    function new();
      start_x = '0;
      start_y = '0;
      start_z = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_INDEX_W-1:0] index, logic [COORD_W-1:0] value);
      case (index)
        REG_START_X: start_x = value;
        REG_START_Y: start_y = value;
        REG_START_Z: start_z = value;
        default: ;
      endcase
    endfunction

    // Scales by the inverse CORDIC gain into guard-bit precision, rounding half away from zero.
    function longint scale_by_inv_gain(logic signed [COORD_W-1:0] coord);
      longint v;
      logic [63:0] mag;
      logic [63:0] scaled;
      v = coord;
      mag = (v < 0) ? -v : v;
      scaled = (mag * INV_GAIN_Q32 + (64'd1 << (31 - GUARD))) >> (32 - GUARD);
      return (v < 0) ? -longint'(scaled) : longint'(scaled);
    endfunction

    function logic [COORD_W-1:0] round_and_clamp(longint v);
      longint t;
      t = (v + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
      if (t > COORD_MAX) t = COORD_MAX;
      if (t < COORD_MIN) t = COORD_MIN;
      return t[COORD_W-1:0];
    endfunction

    function void note_angle(in_item_t item);
      longint x;
      longint y;
      longint residual;
      longint dx;
      longint dy;
      logic [31:0] turn;
      out_item_t point;
      x = scale_by_inv_gain(start_x);
      y = scale_by_inv_gain(start_y);
      turn = {item.turn_angle, {(32 - ANGLE_W){1'b0}}};
      // Angles in the left half plane are folded by a half turn.
      if (turn[31] != turn[30]) begin
        x = -x;
        y = -y;
        turn = turn + 32'h8000_0000;
      end
      residual = longint'($signed(turn));
      for (int i = 0; i < STAGES && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (residual >= 0) begin
          x -= dx;
          y += dy;
          residual -= ATAN_STEP[i];
        end else begin
          x += dx;
          y -= dy;
          residual += ATAN_STEP[i];
        end
      end
      point.rot_x = round_and_clamp(x);
      point.rot_y = round_and_clamp(y);
      point.rot_z = start_z;
      point.final_point = item.final_angle;
      pending_points.push_back(point);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_point(out_item_t got);
      out_item_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected point x=%h y=%h z=%h", got.rot_x, got.rot_y, got.rot_z));
        return;
      end
      want = pending_points.pop_front();
      if (got.rot_x !== want.rot_x)
        report($sformatf("rot_x got %h expected %h", got.rot_x, want.rot_x));
      if (got.rot_y !== want.rot_y)
        report($sformatf("rot_y got %h expected %h", got.rot_y, want.rot_y));
      if (got.rot_z !== want.rot_z)
        report($sformatf("rot_z got %h expected %h", got.rot_z, want.rot_z));
      if (got.final_point !== want.final_point)
        report($sformatf("final_point got %b expected %b", got.final_point, want.final_point));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  rotation_checker checker_h;
  bit steady;
  int cycles;

  z_axis_point_rotator #(
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int kind);
    logic [COORD_W-1:0] v;
    v = $urandom();
    case (kind)
      0: return v;
      1: return {{(COORD_W - 20){v[20]}}, v[19:0]};
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return ($urandom_range(0, 1) == 0) ? '0 : v;
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 7) == 0)
      return ANGLE_W'(($urandom_range(0, 3) << (ANGLE_W - 2)) + $urandom_range(0, 4) - 2);
    return ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) checker_h.check_point(out_data);
  end

  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send_angle(logic [ANGLE_W-1:0] angle, logic last);
    int gap;
    in_item_t item;
    item.turn_angle = angle;
    item.final_angle = last;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    checker_h.note_angle(item);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [COORD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    checker_h.load_reg(index, value);
  endtask

  task automatic load_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, bit spare);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
    write_reg(REG_START_Z, z);
    if (spare) write_reg(REG_SPARE, $urandom());
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (checker_h.pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    checker_h = new();
    steady = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_angle(16'h0000, 1'b0);
    send_angle(16'h5A5A, 1'b1);
    drain();

    load_point(32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF, 1'b0);
    foreach (SWEEP[i]) send_angle(SWEEP[i], (i % 2) == 1);
    drain();

    // Full-scale diagonal points; every angle but zero turns them onto an axis, saturating one output.
    load_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    foreach (DIAGONALS[i]) send_angle(DIAGONALS[i], i == 4);
    drain();
    load_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    foreach (DIAGONALS[i]) send_angle(DIAGONALS[i], i == 4);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady = (p % 4 == 3);
      load_point(pick_coord(p % 4), pick_coord(p % 4), pick_coord(p % 4), p == 1);
      for (int n = 0; n < PHASE_ANGLES; n++)
        send_angle(pick_angle(), n == PHASE_ANGLES - 1 || $urandom_range(0, 15) == 0);
    end
    steady = 1'b0;
    drain();

    if (checker_h.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/zrot_pkg.sv
src/zrot_prescale.sv
src/zrot_cordic_stage.sv
src/zrot_finish.sv
src/z_axis_point_rotator.sv
sim/z_axis_point_rotator_test.sv
